// ===== rtl/lzd_pkg.sv =====
// Shared constants and types for the LZJB decompressor.
package lzd_pkg;

    localparam int WINDOW_SIZE      = 1024;
    localparam int WIN_BITS         = $clog2(WINDOW_SIZE);
    localparam int BANK_DEPTH       = WINDOW_SIZE / 2;
    localparam int BANK_BITS        = WIN_BITS - 1;
    localparam int MAX_OUT_LENGTH   = 65536;
    localparam int LEN_W            = 17;
    localparam int LEN_BITS         = 6;
    localparam int LEN_MIN          = 3;
    localparam int FLAGS_PER_HEADER = 8;
    localparam int OFS_BITS         = 16 - LEN_BITS;
    localparam int MLEN_W           = 7;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW         = QUEUE_AW + 1;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_MATCH,
        CMD_ERR
    } t_cmd_kind;

    // One decoded token: literal byte, back reference or bad-offset report.
    typedef struct packed {
        t_cmd_kind             kind;
        logic [OFS_BITS-1:0]   data;  // literal byte in low bits, or back offset
        logic [MLEN_W-1:0]     len;   // match length after clamping
        logic                  done;  // token ends the block
    } t_cmd;

endpackage

// ===== rtl/lzd_front.sv =====
// Front end: takes compressed bytes, parses headers and tokens, queues commands.
module lzd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_comp_byte,
    input  logic                           i_block_start,
    input  logic [lzd_pkg::LEN_W-1:0]      i_out_length,
    input  logic                           i_full,
    output logic                           o_push,
    output lzd_pkg::t_cmd                  o_cmd
);

    logic [7:0]                  r_flag_byte, n_flag_byte;
    logic [3:0]                  r_flag_pos, n_flag_pos;
    logic [7:0]                  r_high, n_high;
    logic                        r_half, n_half;
    logic [lzd_pkg::LEN_W-1:0]   r_prod, n_prod;
    logic [lzd_pkg::LEN_W-1:0]   r_target, n_target;
    logic                        r_fin, n_fin;

    logic                        accept;
    logic [lzd_pkg::LEN_W-1:0]   len_clamped;
    logic [3:0]                  e_flag_pos;
    logic                        e_half;
    logic [lzd_pkg::LEN_W-1:0]   e_prod;
    logic [lzd_pkg::LEN_W-1:0]   e_target;
    logic                        e_fin;
    logic [lzd_pkg::LEN_W-1:0]   left;
    logic [lzd_pkg::MLEN_W-1:0]  mlen_raw;
    logic [lzd_pkg::MLEN_W-1:0]  mlen;
    logic [lzd_pkg::OFS_BITS-1:0] offset;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    assign len_clamped = (i_out_length > lzd_pkg::LEN_W'(lzd_pkg::MAX_OUT_LENGTH))
                       ? lzd_pkg::LEN_W'(lzd_pkg::MAX_OUT_LENGTH) : i_out_length;

    // block start wipes the parse state before this byte is looked at
    assign e_flag_pos = i_block_start ? 4'(lzd_pkg::FLAGS_PER_HEADER) : r_flag_pos;
    assign e_half     = i_block_start ? 1'b0 : r_half;
    assign e_prod     = i_block_start ? '0 : r_prod;
    assign e_target   = i_block_start ? len_clamped : r_target;
    assign e_fin      = i_block_start ? (len_clamped == '0) : r_fin;

    assign left     = e_target - e_prod;
    assign mlen_raw = lzd_pkg::MLEN_W'(r_high[7:8-lzd_pkg::LEN_BITS])
                    + lzd_pkg::MLEN_W'(lzd_pkg::LEN_MIN);
    assign mlen     = (lzd_pkg::LEN_W'(mlen_raw) > left) ? lzd_pkg::MLEN_W'(left) : mlen_raw;
    assign offset   = {r_high[lzd_pkg::OFS_BITS-9:0], i_comp_byte};

    always_comb begin
        n_flag_byte = r_flag_byte;
        n_flag_pos  = e_flag_pos;
        n_high      = r_high;
        n_half      = e_half;
        n_prod      = e_prod;
        n_target    = e_target;
        n_fin       = e_fin;
        o_push      = 1'b0;
        o_cmd.kind  = lzd_pkg::CMD_LIT;
        o_cmd.data  = lzd_pkg::OFS_BITS'(i_comp_byte);
        o_cmd.len   = '0;
        o_cmd.done  = 1'b0;
        if (!accept) begin
            n_flag_pos = r_flag_pos;
            n_half     = r_half;
            n_prod     = r_prod;
            n_target   = r_target;
            n_fin      = r_fin;
        end else if (!e_fin) begin
            if (e_flag_pos >= 4'(lzd_pkg::FLAGS_PER_HEADER)) begin
                n_flag_byte = i_comp_byte;
                n_flag_pos  = '0;
            end else if (!r_flag_byte[e_flag_pos[2:0]]) begin
                // literal
                n_flag_pos = e_flag_pos + 4'd1;
                n_prod     = e_prod + lzd_pkg::LEN_W'(1);
                n_fin      = (left <= lzd_pkg::LEN_W'(1));
                o_push     = 1'b1;
                o_cmd.kind = lzd_pkg::CMD_LIT;
                o_cmd.done = (left <= lzd_pkg::LEN_W'(1));
            end else if (!e_half) begin
                n_high = i_comp_byte;
                n_half = 1'b1;
            end else begin
                n_half     = 1'b0;
                n_flag_pos = e_flag_pos + 4'd1;
                o_push     = 1'b1;
                o_cmd.data = offset;
                if (offset == '0 || lzd_pkg::LEN_W'(offset) > e_prod) begin
                    o_cmd.kind = lzd_pkg::CMD_ERR;
                    n_fin      = 1'b1;
                end else begin
                    o_cmd.kind = lzd_pkg::CMD_MATCH;
                    o_cmd.len  = mlen;
                    o_cmd.done = (lzd_pkg::LEN_W'(mlen_raw) >= left);
                    n_prod     = e_prod + lzd_pkg::LEN_W'(mlen);
                    n_fin      = (lzd_pkg::LEN_W'(mlen_raw) >= left);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_byte <= '0;
            r_flag_pos  <= 4'(lzd_pkg::FLAGS_PER_HEADER);
            r_high      <= '0;
            r_half      <= 1'b0;
            r_prod      <= '0;
            r_target    <= '0;
            r_fin       <= 1'b1;
        end else begin
            r_flag_byte <= n_flag_byte;
            r_flag_pos  <= n_flag_pos;
            r_high      <= n_high;
            r_half      <= n_half;
            r_prod      <= n_prod;
            r_target    <= n_target;
            r_fin       <= n_fin;
        end
    end

endmodule

// ===== rtl/lzd_cmd_fifo.sv =====
// Small command queue between the token parser and the copy engine.
module lzd_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lzd_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output lzd_pkg::t_cmd   o_cmd,
    output logic            o_empty,
    output logic            o_full
);

    lzd_pkg::t_cmd                r_mem [lzd_pkg::QUEUE_DEPTH];
    logic [lzd_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [lzd_pkg::QUEUE_CW-1:0] r_count;
    logic                         do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == lzd_pkg::QUEUE_CW'(lzd_pkg::QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + lzd_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + lzd_pkg::QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + lzd_pkg::QUEUE_CW'(1);
                2'b01:   r_count <= r_count - lzd_pkg::QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/lzd_back.sv =====
// Back end: history ring in two byte banks, match copy and result register.
module lzd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzd_pkg::t_cmd        i_cmd,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_data_first,
    output logic [7:0]           o_data_second,
    output logic [1:0]           o_byte_count,
    output logic                 o_status,
    output logic                 o_run_last,
    output logic                 o_block_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIT,
        S_ERR,
        S_RD,
        S_WR
    } t_state;

    t_state                          r_state;
    logic [lzd_pkg::WIN_BITS-1:0]    r_wp;
    logic [lzd_pkg::WIN_BITS-1:0]    r_src;
    logic [lzd_pkg::OFS_BITS-1:0]    r_data;
    logic [lzd_pkg::MLEN_W-1:0]      r_rem;
    logic                            r_done;

    logic                            r_out_valid;
    logic [7:0]                      r_first, r_second;
    logic [1:0]                      r_count;
    logic                            r_status, r_last, r_bdone;

    logic [7:0]                      r_bank_even [lzd_pkg::BANK_DEPTH];
    logic [7:0]                      r_bank_odd  [lzd_pkg::BANK_DEPTH];
    logic [7:0]                      r_rd_even, r_rd_odd;
    logic                            r_rd_sel;

    logic                            slot_free;
    logic                            wr_lit, wr_match;
    logic [lzd_pkg::WIN_BITS-1:0]    wp1, src1;
    logic [7:0]                      byte_a, byte_c, first;
    logic [1:0]                      cnt;
    logic                            last;
    logic                            ev_we, od_we;
    logic [lzd_pkg::BANK_BITS-1:0]   ev_waddr, od_waddr, ev_raddr, od_raddr;
    logic [7:0]                      ev_wdata, od_wdata;
    logic                            rd_en;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign wr_lit      = (r_state == S_LIT) && slot_free;
    assign wr_match    = (r_state == S_WR) && slot_free;
    assign rd_en       = (r_state == S_RD);

    assign wp1    = r_wp + lzd_pkg::WIN_BITS'(1);
    assign src1   = r_src + lzd_pkg::WIN_BITS'(1);
    assign byte_a = r_rd_sel ? r_rd_odd : r_rd_even;
    // offset one: the second byte is the one being written now
    assign byte_c = (r_data == lzd_pkg::OFS_BITS'(1)) ? byte_a
                  : (r_rd_sel ? r_rd_even : r_rd_odd);
    assign cnt    = (r_rem >= lzd_pkg::MLEN_W'(2)) ? 2'd2 : 2'd1;
    assign last   = (r_rem <= lzd_pkg::MLEN_W'(2));
    assign first  = (r_state == S_LIT) ? r_data[7:0] : byte_a;

    // bank steering: first byte at wp, second at wp+1
    always_comb begin
        if (!r_wp[0]) begin
            ev_we    = wr_lit || wr_match;
            ev_waddr = r_wp[lzd_pkg::WIN_BITS-1:1];
            ev_wdata = first;
            od_we    = wr_match && (cnt == 2'd2);
            od_waddr = wp1[lzd_pkg::WIN_BITS-1:1];
            od_wdata = byte_c;
        end else begin
            od_we    = wr_lit || wr_match;
            od_waddr = r_wp[lzd_pkg::WIN_BITS-1:1];
            od_wdata = first;
            ev_we    = wr_match && (cnt == 2'd2);
            ev_waddr = wp1[lzd_pkg::WIN_BITS-1:1];
            ev_wdata = byte_c;
        end
        ev_raddr = r_src[0] ? src1[lzd_pkg::WIN_BITS-1:1] : r_src[lzd_pkg::WIN_BITS-1:1];
        od_raddr = r_src[0] ? r_src[lzd_pkg::WIN_BITS-1:1] : src1[lzd_pkg::WIN_BITS-1:1];
    end

    always_ff @(posedge i_clk) begin
        if (ev_we) begin
            r_bank_even[ev_waddr] <= ev_wdata;
        end
        if (rd_en) begin
            r_rd_even <= r_bank_even[ev_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (od_we) begin
            r_bank_odd[od_waddr] <= od_wdata;
        end
        if (rd_en) begin
            r_rd_odd <= r_bank_odd[od_raddr];
            r_rd_sel <= r_src[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_data <= i_cmd.data;
                        r_rem  <= i_cmd.len;
                        r_done <= i_cmd.done;
                        r_src  <= r_wp - lzd_pkg::WIN_BITS'(i_cmd.data);
                        unique case (i_cmd.kind)
                            lzd_pkg::CMD_LIT:   r_state <= S_LIT;
                            lzd_pkg::CMD_MATCH: r_state <= S_RD;
                            default:            r_state <= S_ERR;
                        endcase
                    end
                end
                S_LIT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_first     <= r_data[7:0];
                        r_second    <= '0;
                        r_count     <= 2'd1;
                        r_status    <= 1'b0;
                        r_last      <= 1'b1;
                        r_bdone     <= r_done;
                        r_wp        <= wp1;
                        r_state     <= S_IDLE;
                    end
                end
                S_ERR: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_first     <= '0;
                        r_second    <= '0;
                        r_count     <= 2'd0;
                        r_status    <= 1'b1;
                        r_last      <= 1'b1;
                        r_bdone     <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_first     <= byte_a;
                        r_second    <= (cnt == 2'd2) ? byte_c : 8'd0;
                        r_count     <= cnt;
                        r_status    <= 1'b0;
                        r_last      <= last;
                        r_bdone     <= last && r_done;
                        r_wp        <= r_wp + lzd_pkg::WIN_BITS'(cnt);
                        r_src       <= r_src + lzd_pkg::WIN_BITS'(2);
                        r_rem       <= r_rem - lzd_pkg::MLEN_W'(cnt);
                        r_state     <= last ? S_IDLE : S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_first  = r_first;
    assign o_data_second = r_second;
    assign o_byte_count  = r_count;
    assign o_status      = r_status;
    assign o_run_last    = r_last;
    assign o_block_done  = r_bdone;

endmodule

// ===== rtl/lzjb_decompressor.sv =====
// LZJB decompressor top level: parser, command queue and copy engine.
// Path: a literal goes through the command queue and the copy engine's literal state into the
//   result register; a match's first result goes through the queue, a bank read and a write.
// Throughput: one byte per cycle in while the 4-entry command queue has room; the copy
//   engine steps through idle and literal per literal; per match, idle then read and write per pair.
// Reset (synchronous, active low) idles the block until a block start; history is not cleared.
module lzjb_decompressor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // compressed byte requests
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_comp_byte,
    input  logic                       i_block_start,
    input  logic [lzd_pkg::LEN_W-1:0]  i_out_length,
    // decompressed result requests
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_data_first,
    output logic [7:0]                 o_data_second,
    output logic [1:0]                 o_byte_count,
    output logic                       o_status,
    output logic                       o_run_last,
    output logic                       o_block_done
);

    // Front end tracks output count itself, so it can check offsets and clamp
    // match lengths without waiting on the copy engine.
    logic           push, pop, empty, full;
    lzd_pkg::t_cmd  push_cmd, head_cmd;

    lzd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_comp_byte   (i_comp_byte),
        .i_block_start (i_block_start),
        .i_out_length  (i_out_length),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    lzd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    // Copy engine: the ring pointer runs on across blocks; a legal offset only
    // reaches bytes of the current block.
    lzd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_first  (o_data_first),
        .o_data_second (o_data_second),
        .o_byte_count  (o_byte_count),
        .o_status      (o_status),
        .o_run_last    (o_run_last),
        .o_block_done  (o_block_done)
    );

endmodule
